// File: rtl/sme_pkg.sv
// ---------------------------------------------------------------------------
// sme_pkg: shared types and constants for the stack machine executor
// Opcodes, status codes, sequencer states and the stack depth table.
// ---------------------------------------------------------------------------
`default_nettype none
package sme_pkg;

    localparam int DataWidth = 8;
    localparam int MemDepth  = 256;
    localparam int AddrWidth = 8;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHALLOW  = 2'd1;
    localparam logic [1:0] ST_UNDEF    = 2'd2;
    localparam logic [1:0] ST_EXTERNAL = 2'd3;

    // opcodes
    localparam logic [7:0] OP_PUSH  = 8'h00;
    localparam logic [7:0] OP_DROP  = 8'h01;
    localparam logic [7:0] OP_DUP   = 8'h02;
    localparam logic [7:0] OP_SWAP  = 8'h03;
    localparam logic [7:0] OP_OVER  = 8'h04;
    localparam logic [7:0] OP_ROT   = 8'h05;
    localparam logic [7:0] OP_ADD   = 8'h10;
    localparam logic [7:0] OP_MUL   = 8'h11;
    localparam logic [7:0] OP_SUB   = 8'h12;
    localparam logic [7:0] OP_INC   = 8'h13;
    localparam logic [7:0] OP_DEC   = 8'h14;
    localparam logic [7:0] OP_LT    = 8'h20;
    localparam logic [7:0] OP_GT    = 8'h21;
    localparam logic [7:0] OP_EQ    = 8'h22;
    localparam logic [7:0] OP_NE    = 8'h23;
    localparam logic [7:0] OP_CJUMP = 8'h30;
    localparam logic [7:0] OP_GOTO  = 8'h31;
    localparam logic [7:0] OP_EXT_LO = 8'h40;
    localparam logic [7:0] OP_EXT_HI = 8'h47;
    localparam logic [7:0] OP_NOP   = 8'h50;
    localparam logic [7:0] OP_PRINT = 8'h51;
    localparam logic [7:0] OP_RAND  = 8'h52;
    localparam logic [7:0] OP_PEEK  = 8'h60;
    localparam logic [7:0] OP_POKE  = 8'h61;
    localparam logic [7:0] OP_TPEEK = 8'h62;
    localparam logic [7:0] OP_TPOKE = 8'h63;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,     // opcode read data arrives
        S_DECODE,    // operand reads issued
        S_RD1,       // first stack operand arrives
        S_RD2,       // second operand arrives
        S_RD3,       // third operand arrives
        S_MEMRD,     // indirect read (peek, tpeek, push immediate)
        S_MOD,       // rand: restoring remainder, one bit a cycle
        S_WB1,
        S_WB2,
        S_WB3,
        S_DONE
    } state_t;

    // minimum depth: 0..3, or 4 undefined, 5 external
    localparam logic [2:0] NEED_UNDEF = 3'd4;
    localparam logic [2:0] NEED_EXT   = 3'd5;

    function automatic logic [2:0] need_depth(input logic [7:0] op);
        logic [2:0] n;
        case (op)
            OP_PUSH, OP_NOP: n = 3'd0;
            OP_DROP, OP_DUP, OP_INC, OP_DEC, OP_GOTO,
            OP_PRINT, OP_RAND, OP_PEEK, OP_TPEEK: n = 3'd1;
            OP_SWAP, OP_OVER, OP_ADD, OP_MUL, OP_SUB,
            OP_LT, OP_GT, OP_EQ, OP_NE, OP_CJUMP,
            OP_POKE, OP_TPOKE: n = 3'd2;
            OP_ROT: n = 3'd3;
            default: n = (op >= OP_EXT_LO && op <= OP_EXT_HI) ? NEED_EXT : NEED_UNDEF;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// File: rtl/stack_machine_executor.sv
// ---------------------------------------------------------------------------
// stack_machine_executor: 8-bit stack machine
// Executes one instruction or loads one program byte per input item.
// ---------------------------------------------------------------------------
// One item at a time. A load writes one program byte and ends. A step runs
// opcode fetch, up to three stack reads through the single stack RAM port,
// an optional indirect read and up to three stack writes; rand adds a
// bit-serial remainder unit. The one-port program and stack RAMs force this
// serial order. The result waits in an output register while the next item
// runs; a finished item holds in its last state until that register is free.
`default_nettype none
module stack_machine_executor
    import sme_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // load_address[7:0], load_data[15:8], random_value[23:16]
    input  wire logic [23:0] s_tdata,
    // mode
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], opcode_seen[9:2], next_pc[17:10], print_valid[18],
    // print_value[26:19], stack_depth[34:27], zero pad 39:35
    output logic [39:0]      m_tdata
);
    localparam int AW = AddrWidth;

    state_t state_reg, state_next;
    logic [AW-1:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [7:0] op_reg, op_next;
    logic [7:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [7:0] rnd_reg, rnd_next;
    logic [8:0] rem_reg, rem_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] st_reg, st_next;
    logic       pv_reg, pv_next, out_v_reg, out_v_next;
    logic [39:0] out_reg, out_next;

    logic          p_we, s_we;
    logic [AW-1:0] p_addr, s_addr;
    logic [7:0]    p_wdata, s_wdata, p_rdata, s_rdata;
    logic [8:0]    rem_sh;
    logic [15:0]   prod;

    sme_ram #(.Width(DataWidth), .Depth(MemDepth)) u_prog (
        .aclk(aclk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));
    sme_ram #(.Width(DataWidth), .Depth(MemDepth)) u_stack (
        .aclk(aclk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
    assign prod     = a_reg * b_reg;
    assign rem_sh   = {rem_reg[7:0], rnd_reg[7]};

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            sp_reg    <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; a_reg <= a_next; b_reg <= b_next; c_reg <= c_next;
        rnd_reg <= rnd_next;
        rem_reg <= rem_next; cnt_reg <= cnt_next; st_reg <= st_next;
        pv_reg <= pv_next; out_reg <= out_next;
    end

    // sequencer
    always_comb begin
        state_next = state_reg; pc_next = pc_reg; sp_next = sp_reg;
        op_next = op_reg; a_next = a_reg; b_next = b_reg; c_next = c_reg;
        rnd_next = rnd_reg;
        rem_next = rem_reg; cnt_next = cnt_reg; st_next = st_reg; pv_next = pv_reg;
        out_v_next = out_v_reg; out_next = out_reg;
        p_we = 1'b0; p_addr = pc_reg; p_wdata = s_tdata[15:8];
        s_we = 1'b0; s_addr = sp_reg - AW'(1); s_wdata = a_reg;
        if (out_v_reg && m_tready) out_v_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    rnd_next = s_tdata[23:16];
                    op_next = OP_PUSH; st_next = ST_OK; pv_next = 1'b0;
                    a_next = '0;
                    if (s_tuser) begin
                        p_we = 1'b1; p_addr = AW'(s_tdata[7:0]); p_wdata = s_tdata[15:8];
                        op_next = '0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                op_next = p_rdata;
                pc_next = pc_reg + AW'(1);
                state_next = S_DECODE;
            end
            S_DECODE: begin
                // check depth, issue top read or immediate fetch
                if (need_depth(op_reg) == NEED_UNDEF) begin
                    st_next = ST_UNDEF; state_next = S_DONE;
                end else if (need_depth(op_reg) == NEED_EXT) begin
                    st_next = ST_EXTERNAL; state_next = S_DONE;
                end else if ({5'd0, need_depth(op_reg)} > 8'(sp_reg)) begin
                    st_next = ST_SHALLOW; state_next = S_DONE;
                end else if (op_reg == OP_PUSH) begin
                    p_addr = pc_reg; state_next = S_MEMRD;
                end else if (op_reg == OP_NOP) begin
                    state_next = S_DONE;
                end else begin
                    s_addr = sp_reg - AW'(1); state_next = S_RD1;
                end
            end
            S_RD1: begin
                // a = top; fetch second for two-deep ops
                a_next = s_rdata;
                s_addr = sp_reg - AW'(2);
                case (op_reg)
                    OP_DROP: begin sp_next = sp_reg - AW'(1); state_next = S_DONE; end
                    OP_DUP: state_next = S_WB1;
                    OP_PRINT: begin pv_next = 1'b1; state_next = S_DONE; end
                    OP_GOTO: begin
                        pc_next = s_rdata; sp_next = sp_reg - AW'(1); state_next = S_DONE;
                    end
                    OP_INC: begin a_next = s_rdata + 8'd1; state_next = S_WB1; end
                    OP_DEC: begin a_next = s_rdata - 8'd1; state_next = S_WB1; end
                    OP_PEEK: begin s_addr = s_rdata; state_next = S_MEMRD; end
                    OP_TPEEK: begin p_addr = s_rdata; state_next = S_MEMRD; end
                    OP_RAND: begin
                        rem_next = '0; cnt_next = '0;
                        state_next = (s_rdata == 8'd0) ? S_WB1 : S_MOD;
                    end
                    default: state_next = S_RD2;
                endcase
            end
            S_RD2: begin
                b_next = s_rdata;
                s_addr = sp_reg - AW'(3);
                state_next = S_WB1;
                case (op_reg)
                    OP_ROT: state_next = S_RD3;
                    OP_OVER: a_next = s_rdata;
                    OP_ADD: a_next = s_rdata + a_reg;
                    OP_SUB: a_next = s_rdata - a_reg;
                    OP_MUL: b_next = s_rdata;
                    OP_LT: a_next = {7'd0, s_rdata < a_reg};
                    OP_GT: a_next = {7'd0, s_rdata > a_reg};
                    OP_EQ: a_next = {7'd0, s_rdata == a_reg};
                    OP_NE: a_next = {7'd0, s_rdata != a_reg};
                    OP_CJUMP: begin
                        if (s_rdata != 8'd0) pc_next = a_reg;
                        sp_next = sp_reg - AW'(2); state_next = S_DONE;
                    end
                    OP_POKE: begin
                        s_we = 1'b1; s_addr = a_reg; s_wdata = s_rdata;
                        sp_next = sp_reg - AW'(2); state_next = S_DONE;
                    end
                    OP_TPOKE: begin
                        p_we = 1'b1; p_addr = a_reg; p_wdata = s_rdata;
                        sp_next = sp_reg - AW'(2); state_next = S_DONE;
                    end
                    default: ;
                endcase
            end
            S_RD3: begin
                c_next = s_rdata;
                state_next = S_WB1;
            end
            S_MEMRD: begin
                // indirect or immediate byte replaces/pushes top
                if (op_reg == OP_PEEK) a_next = s_rdata;
                else a_next = p_rdata;
                if (op_reg == OP_PUSH) pc_next = pc_reg + AW'(1);
                state_next = S_WB1;
            end
            S_MOD: begin
                // restoring remainder of rnd / a
                if (rem_sh >= {1'b0, a_reg}) rem_next = rem_sh - {1'b0, a_reg};
                else rem_next = rem_sh;
                rnd_next = {rnd_reg[6:0], 1'b0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) state_next = S_WB1;
            end
            S_WB1: begin
                s_we = 1'b1;
                state_next = S_DONE;
                case (op_reg)
                    OP_PUSH, OP_DUP, OP_OVER: begin
                        s_addr = sp_reg; sp_next = sp_reg + AW'(1);
                    end
                    OP_INC, OP_DEC, OP_PEEK, OP_TPEEK: s_addr = sp_reg - AW'(1);
                    OP_RAND: begin
                        s_addr = sp_reg - AW'(1);
                        s_wdata = (a_reg == 8'd0) ? 8'd0 : rem_reg[7:0];
                    end
                    OP_MUL: begin
                        s_addr = sp_reg - AW'(2); s_wdata = prod[7:0];
                        sp_next = sp_reg - AW'(1);
                    end
                    OP_SWAP: begin
                        s_addr = sp_reg - AW'(2); state_next = S_WB2;
                    end
                    OP_ROT: begin
                        // c b a(top) -> b a c
                        s_addr = sp_reg - AW'(3); s_wdata = b_reg; state_next = S_WB2;
                    end
                    default: begin
                        // add, sub, compares
                        s_addr = sp_reg - AW'(2); sp_next = sp_reg - AW'(1);
                    end
                endcase
            end
            S_WB2: begin
                s_we = 1'b1;
                state_next = S_DONE;
                if (op_reg == OP_ROT) begin
                    s_addr = sp_reg - AW'(2); s_wdata = a_reg; state_next = S_WB3;
                end else begin
                    s_addr = sp_reg - AW'(1); s_wdata = b_reg;
                end
            end
            S_WB3: begin
                s_we = 1'b1; s_addr = sp_reg - AW'(1); s_wdata = c_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!out_v_reg || m_tready) begin
                    out_v_next = 1'b1;
                    out_next = {5'd0, 8'(sp_reg), (pv_reg ? a_reg : 8'd0), pv_reg,
                                8'(pc_reg), op_reg, st_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTH
    // result is never overwritten before it is taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // a finished item waits while the previous result is held
    a_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && state_reg == S_DONE |=> state_reg == S_DONE)
        else $error("item completed over a pending result");
    // a result only follows the done state
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result without completion");
`endif
endmodule
`default_nettype wire

// File: rtl/sme_ram.sv
// ---------------------------------------------------------------------------
// sme_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module sme_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
